// File: design/sha1_pkg.sv
// Shared constants and types for the SHA-1 stream hasher.
package sha1_pkg;

  localparam int WordW     = 32;
  localparam int BlockDepth = 16;
  localparam int QueueDepth = 4;
  localparam int Rounds    = 80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] PadWord = 32'h80000000;

  // Classified word handed from the front end to the core.
  typedef enum logic [1:0] {
    OP_DATA,   // plain block word
    OP_PAD,    // padding-produced word
    OP_LEN_HI, // last word before length low; no digest
    OP_FINAL   // length low word: emit digest after the block
  } op_t;

  typedef struct packed {
    logic [31:0] word;
    op_t         op;
  } qitem_t;

endpackage

// File: design/sha1_front.sv
// Front end: takes message words, builds padding and length words.
module sha1_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          message_word,
  input  logic [2:0]           valid_bytes,
  input  logic                 last_word,
  output logic                 q_valid,
  input  logic                 q_full,
  output sha1_pkg::qitem_t     q_item
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {S_IN, S_PAD80, S_ZERO, S_LENHI, S_LENLO} state_t;

  state_t      state;
  logic [3:0]  pos;
  logic [63:0] bit_len;
  logic [2:0]  nb;
  logic [31:0] keep;
  logic [31:0] tail;
  logic [63:0] len_next;

  // Saturate byte count and build the final data word
  always_comb begin
    nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    case (nb)
      3'd0:    begin keep = 32'h0;        tail = 32'h80000000; end
      3'd1:    begin keep = 32'hFF000000; tail = 32'h00800000; end
      3'd2:    begin keep = 32'hFFFF0000; tail = 32'h00008000; end
      3'd3:    begin keep = 32'hFFFFFF00; tail = 32'h00000080; end
      default: begin keep = 32'hFFFFFFFF; tail = 32'h0;        end
    endcase
    len_next = bit_len + (last_word ? {58'd0, nb, 3'd0} : 64'd32);
  end

  assign in_stall = (state != S_IN) || q_full;

  // Drive the queue from the current state
  always_comb begin
    q_valid = 1'b0;
    q_item  = '{word: 32'h0, op: OP_DATA};
    unique case (state)
      S_IN: begin
        q_valid = in_valid;
        q_item  = '{word: last_word ? ((message_word & keep) | tail) : message_word,
                    op: OP_DATA};
      end
      S_PAD80: begin q_valid = 1'b1; q_item = '{word: PadWord, op: OP_PAD}; end
      S_ZERO:  begin q_valid = 1'b1; q_item = '{word: 32'h0, op: OP_PAD}; end
      S_LENHI: begin q_valid = 1'b1; q_item = '{word: bit_len[63:32], op: OP_LEN_HI}; end
      S_LENLO: begin q_valid = 1'b1; q_item = '{word: bit_len[31:0], op: OP_FINAL}; end
      default: ;
    endcase
  end

  // Advance sequencing on each queue transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IN;
      pos     <= 4'd0;
      bit_len <= 64'd0;
    end else if (q_valid && !q_full) begin
      pos <= pos + 4'd1;
      unique case (state)
        S_IN: begin
          bit_len <= len_next;
          if (last_word) begin
            if (nb == 3'd4)           state <= S_PAD80;
            else if (pos == 4'd13)    state <= S_LENHI;
            else                      state <= S_ZERO;
          end
        end
        S_PAD80, S_ZERO: state <= (pos == 4'd13) ? S_LENHI : S_ZERO;
        S_LENHI: state <= S_LENLO;
        S_LENLO: begin
          state   <= S_IN;
          pos     <= 4'd0;
          bit_len <= 64'd0;
        end
        default: state <= S_IN;
      endcase
    end
  end
endmodule

// File: design/sha1_queue.sv
// Short FIFO between the front end and the compression core.
module sha1_queue #(
  parameter int Depth = sha1_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             full,
  input  sha1_pkg::qitem_t wr_item,
  output logic             rd_valid,
  input  logic             rd_take,
  output sha1_pkg::qitem_t rd_item
);
  import sha1_pkg::*;

  localparam int AW = $clog2(Depth);

  qitem_t        mem [Depth];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == Depth[AW:0]);
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rp];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_take && rd_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_item;
  end

  // Track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

// File: design/sha1_core.sv
// Compression core: loads block words, runs 80 rounds, emits digest.
module sha1_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_take,
  input  sha1_pkg::qitem_t q_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       digest_index,
  output logic             digest_last
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_ROUND, S_SUM, S_EMIT} state_t;

  state_t      state;
  logic [31:0] w [BlockDepth];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [3:0]  pos;
  logic        fin;
  logic [2:0]  idx;
  logic [3:0]  t4;
  logic [31:0] wx, wt, f, k, tmp;

  // Round function and schedule expansion
  always_comb begin
    t4 = rnd[3:0];
    wx = w[t4 + 4'd13] ^ w[t4 + 4'd8] ^ w[t4 + 4'd2] ^ w[t4];
    wt = (rnd >= 7'd16) ? {wx[30:0], wx[31]} : w[t4];
    if (rnd < 7'd20)      begin f = (b & c) | (~b & d);          k = K0; end
    else if (rnd < 7'd40) begin f = b ^ c ^ d;                   k = K1; end
    else if (rnd < 7'd60) begin f = (b & c) | (b & d) | (c & d); k = K2; end
    else                  begin f = b ^ c ^ d;                   k = K3; end
    tmp = {a[26:0], a[31:27]} + f + e + wt + k;
  end

  assign q_take       = (state == S_LOAD);
  assign out_valid    = (state == S_EMIT);
  assign digest_word  = h[idx];
  assign digest_index = idx;
  assign digest_last  = (idx == 3'd4);

  // Sequence load, rounds, chain update and digest output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pos   <= 4'd0;
      rnd   <= 7'd0;
      idx   <= 3'd0;
      fin   <= 1'b0;
      h     <= '{H0, H1, H2, H3, H4};
    end else begin
      unique case (state)
        S_LOAD: if (q_valid) begin
          w[pos] <= q_item.word;
          pos    <= pos + 4'd1;
          if (pos == 4'd15) begin
            fin   <= (q_item.op == OP_FINAL);
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            rnd   <= 7'd0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          w[t4] <= wt;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(Rounds - 1)) state <= S_SUM;
        end
        S_SUM: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          idx   <= 3'd0;
          state <= fin ? S_EMIT : S_LOAD;
        end
        S_EMIT: if (!out_stall) begin
          idx <= idx + 3'd1;
          if (idx == 3'd4) begin
            h     <= '{H0, H1, H2, H3, H4};
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// File: design/sha1_stream_hasher_top.sv
// SHA-1 stream hasher top level: front end, queue and compression core.
// Each 16-word block is loaded from the queue, then compressed one round per cycle
// (80 rounds plus a chain-update step). A four-entry queue lets the front end
// keep taking words while the core runs, until the queue is full. On the last
// word the front end adds padding and length words at one per cycle while the
// queue is not full, then the five digest words leave H0 first, one per transfer.
module sha1_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);
  import sha1_pkg::*;

  logic   fq_valid, fq_full, qc_valid, qc_take;
  qitem_t fq_item, qc_item;

  sha1_front u_front (
    .clk, .rst, .in_valid, .in_stall, .message_word, .valid_bytes, .last_word,
    .q_valid(fq_valid), .q_full(fq_full), .q_item(fq_item)
  );

  sha1_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(fq_valid), .full(fq_full), .wr_item(fq_item),
    .rd_valid(qc_valid), .rd_take(qc_take), .rd_item(qc_item)
  );

  sha1_core u_core (
    .clk, .rst, .q_valid(qc_valid), .q_take(qc_take), .q_item(qc_item),
    .out_valid, .out_stall, .digest_word, .digest_index, .digest_last
  );
endmodule

// File: tb/tb_sha1_stream_hasher_top.sv
// Self-checking testbench for the SHA-1 stream hasher: directed and random messages.
module tb_sha1_stream_hasher_top;
  import sha1_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  // Running hash state of the predictor
  logic [31:0] chain_h [5];
  logic [31:0] block_w [16];
  logic [3:0]  slot;
  logic [63:0] msg_bits;

  digest_t     pending_digests [$];
  int          fail_count;
  int          word_count;
  int          digest_count;
  int          message_count;
  bit          out_stall_on;

  sha1_stream_hasher_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .message_word(message_word), .valid_bytes(valid_bytes), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .digest_index(digest_index), .digest_last(digest_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rotl32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Run the 80 rounds on the gathered block and fold into the chain
  task automatic compress_block();
    logic [31:0] a, b, c, d, e, f, k, t, w;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = block_w[(r - 3) & 15] ^ block_w[(r - 8) & 15] ^
            block_w[(r - 14) & 15] ^ block_w[r & 15];
        block_w[r & 15] = rotl32(w, 1);
      end
      w = block_w[r & 15];
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rotl32(a, 5) + f + e + w + k;
      e = d; d = c; c = rotl32(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  task automatic push_block_word(logic [31:0] w);
    block_w[slot] = w;
    slot = slot + 4'd1;
    if (slot == 4'd0) compress_block();
  endtask

  task automatic reset_chain();
    chain_h[0] = H0; chain_h[1] = H1; chain_h[2] = H2; chain_h[3] = H3; chain_h[4] = H4;
    slot = '0;
    msg_bits = '0;
  endtask

  // Update the hash for one accepted word; queue the digest on the last word
  task automatic predict_digest(logic [31:0] w, logic [2:0] nb, logic fin);
    int n;
    logic [31:0] keep;
    digest_t d;
    if (!fin) begin
      msg_bits += 64'd32;
      push_block_word(w);
      return;
    end
    n = (nb > 3'd4) ? 4 : int'(nb);
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      push_block_word(w);
      push_block_word(PadWord);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
      push_block_word((w & keep) | (32'h80 << (24 - 8 * n)));
    end
    while (slot != 4'd14) push_block_word(32'h0);
    push_block_word(msg_bits[63:32]);
    push_block_word(msg_bits[31:0]);
    for (int i = 0; i < 5; i++) begin
      d.word = chain_h[i];
      d.index = 3'(i);
      d.last = (i == 4);
      pending_digests.push_back(d);
    end
    message_count++;
    reset_chain();
  endtask

  // Drive one word and hold it until the transfer; drop valid only over a gap
  task automatic send_word(logic [31:0] w, logic [2:0] nb, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    message_word <= w;
    valid_bytes <= nb;
    last_word <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(w, nb, fin);
    word_count++;
  endtask

  task automatic send_message(int len, logic [2:0] final_nb);
    for (int i = 0; i < len; i++) send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom(), final_nb, 1'b1);
  endtask

  // Edge values, valid-byte counts zero to five and seven, and padding across a block boundary
  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);            // empty message
    send_word(32'h6162_6300, 3'd3, 1'b1);    // "abc"
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);    // saturates to four
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    send_word(32'hA5A5_A5A5, 3'd5, 1'b1);
    send_message(13, 3'd4);                  // pad forces a second block
    send_message(12, 3'd3);
  endtask

  // Random messages, mostly short, a few spanning several blocks
  task automatic test_random_messages();
    int len;
    while (word_count < 410) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 16);
      send_message(len, 3'($urandom_range(0, 7)));
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_on = !out_stall_on && ($urandom_range(0, 9) < 3);
      out_stall <= out_stall_on;
    end
  end

  // Compare each digest transfer with the oldest expectation
  always @(posedge clk) begin
    digest_t d;
    if (!rst && out_valid && !out_stall) begin
      digest_count++;
      if (pending_digests.size() == 0) begin
        $error("unexpected digest word %h", digest_word);
        fail_count++;
      end else begin
        d = pending_digests.pop_front();
        if (digest_word !== d.word) begin
          $error("digest_word expected %h actual %h", d.word, digest_word);
          fail_count++;
        end
        if (digest_index !== d.index) begin
          $error("digest_index expected %0d actual %0d", d.index, digest_index);
          fail_count++;
        end
        if (digest_last !== d.last) begin
          $error("digest_last expected %0d actual %0d", d.last, digest_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    message_word = '0;
    valid_bytes = '0;
    last_word = 1'b0;
    fail_count = 0;
    word_count = 0;
    digest_count = 0;
    message_count = 0;
    reset_chain();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_messages();
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d words in %0d messages, %0d digest words checked.",
             word_count, message_count, digest_count);
    if (fail_count == 0 && pending_digests.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hold a hard limit on run time
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
design/sha1_pkg.sv
design/sha1_front.sv
design/sha1_queue.sv
design/sha1_core.sv
design/sha1_stream_hasher_top.sv
tb/tb_sha1_stream_hasher_top.sv
